>>> hw/rtl/rv32im_instruction_encoder_macros.svh
// Assertion macros shared by the encoder RTL.
`ifndef RV32IM_INSTRUCTION_ENCODER_MACROS_SVH
`define RV32IM_INSTRUCTION_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

`define RVENC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvenc assertion failed");

`define RVENC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvenc assertion failed");

`else

`define RVENC_ASSERT_SAME(lbl, ante, cons)

`define RVENC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hw/rtl/rvenc_pkg.sv
// Types, opcodes and field tables for the RV32IM instruction encoder.
`default_nettype none

package rvenc_pkg;

    localparam logic [6:0] OP_R    = 7'h33;
    localparam logic [6:0] OP_I    = 7'h13;
    localparam logic [6:0] OP_B    = 7'h63;
    localparam logic [6:0] OP_S    = 7'h23;
    localparam logic [6:0] OP_L    = 7'h03;
    localparam logic [6:0] OP_JAL  = 7'h6F;
    localparam logic [6:0] OP_JALR = 7'h67;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    localparam logic [31:0] PC_STEP = 32'd4;

    typedef enum logic [5:0] {
        FN_ADD, FN_SUB, FN_SLL, FN_SLT, FN_SLTU, FN_XOR, FN_SRL, FN_SRA,
        FN_OR, FN_AND, FN_MUL, FN_DIV, FN_DIVU, FN_REM, FN_REMU,
        FN_ADDI, FN_SLTI, FN_SLTIU, FN_XORI, FN_ORI, FN_ANDI,
        FN_SLLI, FN_SRLI, FN_SRAI,
        FN_LB, FN_LH, FN_LW, FN_LBU, FN_LHU,
        FN_SB, FN_SH, FN_SW,
        FN_BEQ, FN_BNE, FN_BLT, FN_BGE, FN_BLTU, FN_BGEU,
        FN_JAL, FN_JALR,
        FN_MV, FN_LI, FN_J, FN_JR, FN_RET, FN_NOP, FN_BLE, FN_BGT,
        FN_BEQZ, FN_BNEZ, FN_BGEZ, FN_BLTZ, FN_SEQZ, FN_SNEZ, FN_SLTZ, FN_SGTZ
    } func_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_ODD_OFFSET,
        ST_UNKNOWN_OP
    } status_t;

    typedef struct packed {
        logic [5:0]  func;
        logic [4:0]  dest_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic [31:0] immediate;
        logic        use_label;
        logic [31:0] label_address;
        logic [31:0] pc;
    } item_t;

    typedef struct packed {
        logic [31:0] machine_word;
        status_t     status;
    } result_t;

    function automatic logic [2:0] funct3_of(input func_t f);
        logic [2:0] f3;
        f3 = 3'd0;
        unique case (f)
            FN_SLL, FN_SLLI, FN_LH, FN_SH, FN_BNE:          f3 = 3'd1;
            FN_SLT, FN_SLTI, FN_LW, FN_SW:                  f3 = 3'd2;
            FN_SLTU, FN_SLTIU:                              f3 = 3'd3;
            FN_XOR, FN_DIV, FN_XORI, FN_LBU, FN_BLT:        f3 = 3'd4;
            FN_SRL, FN_SRA, FN_DIVU, FN_SRLI, FN_SRAI,
            FN_LHU, FN_BGE:                                 f3 = 3'd5;
            FN_OR, FN_REM, FN_ORI, FN_BLTU:                 f3 = 3'd6;
            FN_AND, FN_REMU, FN_ANDI, FN_BGEU:              f3 = 3'd7;
            default:                                        f3 = 3'd0;
        endcase
        return f3;
    endfunction

    function automatic logic [6:0] funct7_of(input func_t f);
        logic [6:0] f7;
        f7 = F7_BASE;
        unique case (f)
            FN_SUB, FN_SRA, FN_SRAI:                        f7 = F7_ALT;
            FN_MUL, FN_DIV, FN_DIVU, FN_REM, FN_REMU:       f7 = F7_MULDIV;
            default:                                        f7 = F7_BASE;
        endcase
        return f7;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rvenc_encode.sv
// Combinational pseudo expansion and RV32IM field packing for one request.
`default_nettype none

module rvenc_encode (
    input  rvenc_pkg::item_t   item,
    output rvenc_pkg::result_t result
);

    rvenc_pkg::func_t f;
    logic [4:0]       rd;
    logic [4:0]       a;
    logic [4:0]       b;
    logic [31:0]      imm;
    logic [31:0]      off;
    logic [2:0]       f3;
    logic [6:0]       f7;

    always_comb
    begin
        f   = rvenc_pkg::func_t'(item.func);
        rd  = item.dest_reg;
        a   = item.src1_reg;
        b   = item.src2_reg;
        imm = item.immediate;

        // expand pseudo forms into their base instruction
        unique case (f)
            rvenc_pkg::FN_MV:
            begin
                f = rvenc_pkg::FN_ADDI; imm = '0;
            end
            rvenc_pkg::FN_LI:
            begin
                f = rvenc_pkg::FN_ADDI; a = '0;
            end
            rvenc_pkg::FN_J:
            begin
                f = rvenc_pkg::FN_JAL; rd = '0;
            end
            rvenc_pkg::FN_JR:
            begin
                f = rvenc_pkg::FN_JALR; rd = '0; imm = '0;
            end
            rvenc_pkg::FN_RET:
            begin
                f = rvenc_pkg::FN_JALR; rd = '0; a = 5'd1; imm = '0;
            end
            rvenc_pkg::FN_NOP:
            begin
                f = rvenc_pkg::FN_ADDI; rd = '0; a = '0; imm = '0;
            end
            rvenc_pkg::FN_BLE:
            begin
                f = rvenc_pkg::FN_BGE; a = item.src2_reg; b = item.src1_reg;
            end
            rvenc_pkg::FN_BGT:
            begin
                f = rvenc_pkg::FN_BLT; a = item.src2_reg; b = item.src1_reg;
            end
            rvenc_pkg::FN_BEQZ:
            begin
                f = rvenc_pkg::FN_BEQ; b = '0;
            end
            rvenc_pkg::FN_BNEZ:
            begin
                f = rvenc_pkg::FN_BNE; b = '0;
            end
            rvenc_pkg::FN_BGEZ:
            begin
                f = rvenc_pkg::FN_BGE; b = '0;
            end
            rvenc_pkg::FN_BLTZ:
            begin
                f = rvenc_pkg::FN_BLT; b = '0;
            end
            rvenc_pkg::FN_SEQZ:
            begin
                f = rvenc_pkg::FN_SLTIU; imm = 32'd1;
            end
            rvenc_pkg::FN_SNEZ:
            begin
                f = rvenc_pkg::FN_SLTU; b = item.src1_reg; a = '0;
            end
            rvenc_pkg::FN_SLTZ:
            begin
                f = rvenc_pkg::FN_SLT; b = '0;
            end
            rvenc_pkg::FN_SGTZ:
            begin
                f = rvenc_pkg::FN_SLT; b = item.src1_reg; a = '0;
            end
            default:
            begin
                f = rvenc_pkg::func_t'(item.func);
            end
        endcase

        off = item.use_label ? (item.label_address - item.pc) : imm;
        f3  = rvenc_pkg::funct3_of(f);
        f7  = rvenc_pkg::funct7_of(f);

        result.machine_word = '0;
        result.status       = rvenc_pkg::ST_OK;

        priority if (f <= rvenc_pkg::FN_REMU)
        begin
            result.machine_word = {f7, b, a, f3, rd, rvenc_pkg::OP_R};
        end
        else if (f <= rvenc_pkg::FN_ANDI)
        begin
            result.machine_word = {imm[11:0], a, f3, rd, rvenc_pkg::OP_I};
        end
        else if (f <= rvenc_pkg::FN_SRAI)
        begin
            result.machine_word = {f7, imm[4:0], a, f3, rd, rvenc_pkg::OP_I};
        end
        else if (f <= rvenc_pkg::FN_LHU)
        begin
            result.machine_word = {imm[11:0], a, f3, rd, rvenc_pkg::OP_L};
        end
        else if (f <= rvenc_pkg::FN_SW)
        begin
            result.machine_word = {imm[11:5], b, a, f3, imm[4:0], rvenc_pkg::OP_S};
        end
        else if (f <= rvenc_pkg::FN_JAL)
        begin
            priority if (off[0])
            begin
                result.status = rvenc_pkg::ST_ODD_OFFSET;
            end
            else if (f == rvenc_pkg::FN_JAL)
            begin
                result.machine_word = {off[20], off[10:1], off[11], off[19:12], rd,
                                       rvenc_pkg::OP_JAL};
            end
            else
            begin
                result.machine_word = {off[12], off[10:5], b, a, f3, off[4:1], off[11],
                                       rvenc_pkg::OP_B};
            end
        end
        else if (f == rvenc_pkg::FN_JALR)
        begin
            result.machine_word = {imm[11:0], a, 3'd0, rd, rvenc_pkg::OP_JALR};
        end
        else
        begin
            result.status = rvenc_pkg::ST_UNKNOWN_OP;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rv32im_instruction_encoder.sv
// Top level of the RV32IM instruction encoder: request register, encoder, result register.
// Usage:
//   Request channel (req_valid / req_stall) carries one tokenized instruction: func,
//   dest_reg, src1_reg, src2_reg, immediate, use_label and label_address.
//   Response channel (rsp_valid / rsp_stall) returns machine_word and status
//   (ok, odd branch or jump offset, unknown operation; machine_word is zero on error).
//   A request is taken at a rising edge with valid high and stall low.
//   The program counter that labels are measured against starts at 0 and advances
//   by 4 on every accepted request, errors included, wrapping at 2^32.
// Path: an accepted request is held in the request register, encoded combinationally, and
//   then captured in the result register, which drives the response.
// Throughput: one instruction per cycle unless rsp_stall holds; the request register feeds
//   the encoder and result register; each stage advances whenever the next one is free.
// Stall: while rsp_stall holds a response, one further request is still taken into
//   the request register; req_stall rises only once both registers are full.
// Reset: rst_n low clears the program counter and both valid flags at once;
//   no response is pending after reset.
`default_nettype none

module rv32im_instruction_encoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic [5:0]         func,
    input  wire logic [4:0]         dest_reg,
    input  wire logic [4:0]         src1_reg,
    input  wire logic [4:0]         src2_reg,
    input  wire logic signed [31:0] immediate,
    input  wire logic               use_label,
    input  wire logic [31:0]        label_address,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic [31:0]             machine_word,
    output logic [1:0]              status
);

`include "rv32im_instruction_encoder_macros.svh"

    logic [31:0]        pc_cnt_reg;
    logic [31:0]        pc_cnt_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    rvenc_pkg::item_t   s1_item_reg;
    rvenc_pkg::item_t   s1_item_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rvenc_pkg::result_t rsp_reg;
    rvenc_pkg::result_t enc_result;
    logic               s2_free;
    logic               req_accept;

    assign s2_free    = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = s1_valid_reg && !s2_free;
    assign req_accept = req_valid && !req_stall;

    always_comb
    begin
        pc_cnt_next    = req_accept ? (pc_cnt_reg + rvenc_pkg::PC_STEP) : pc_cnt_reg;
        s1_valid_next  = req_stall ? 1'b1 : req_valid;
        rsp_valid_next = s2_free ? s1_valid_reg : 1'b1;

        s1_item_next.func          = func;
        s1_item_next.dest_reg      = dest_reg;
        s1_item_next.src1_reg      = src1_reg;
        s1_item_next.src2_reg      = src2_reg;
        s1_item_next.immediate     = immediate;
        s1_item_next.use_label     = use_label;
        s1_item_next.label_address = label_address;
        s1_item_next.pc            = pc_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_cnt_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pc_cnt_reg    <= pc_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // hold the request while the result register is blocked
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_item_reg <= s1_item_next;
        end
        if (s2_free)
        begin
            rsp_reg <= enc_result;
        end
    end

    rvenc_encode u_encode (
        .item   (s1_item_reg),
        .result (enc_result)
    );

    assign rsp_valid    = rsp_valid_reg;
    assign machine_word = rsp_reg.machine_word;
    assign status       = rsp_reg.status;

    `RVENC_ASSERT_SAME(a_error_zero_word,
        rsp_valid_reg && status != rvenc_pkg::ST_OK, machine_word == 32'd0)
    `RVENC_ASSERT_SAME(a_status_legal, rsp_valid_reg,
        status == rvenc_pkg::ST_OK || status == rvenc_pkg::ST_ODD_OFFSET ||
        status == rvenc_pkg::ST_UNKNOWN_OP)
    `RVENC_ASSERT_NEXT(a_pc_advance, req_accept,
        pc_cnt_reg == $past(pc_cnt_reg) + rvenc_pkg::PC_STEP)
    `RVENC_ASSERT_NEXT(a_pc_hold, !req_accept, $stable(pc_cnt_reg))
    `RVENC_ASSERT_SAME(a_stall_needs_full, req_stall, s1_valid_reg && rsp_valid_reg)

endmodule

`default_nettype wire
